### src/stepper_ramp_pulse_generator_assert.svh
// Assertion macros used by the checker of the stepper ramp pulse generator.
`ifndef STEPPER_RAMP_PULSE_GENERATOR_ASSERT_SVH
`define STEPPER_RAMP_PULSE_GENERATOR_ASSERT_SVH

// Same-cycle implication, sampled on clk_i and disabled during reset.
`define SRPG_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("srpg check failed");

// Next-cycle implication, sampled on clk_i and disabled during reset.
`define SRPG_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("srpg check failed");

`endif

### src/srpg_pkg.sv
// Types and constants of the stepper ramp pulse generator.
`default_nettype none
package srpg_pkg;

  localparam int unsigned PeriodW = 16;
  localparam int unsigned CountW  = 16;
  localparam int unsigned CfgIdxW = 1;

  localparam logic [PeriodW-1:0] UpperReset = 16'd875;
  localparam logic [PeriodW-1:0] LowerReset = 16'd825;

  localparam logic [CfgIdxW-1:0] CFG_UPPER = 1'b0;
  localparam logic [CfgIdxW-1:0] CFG_LOWER = 1'b1;

  localparam logic FUNC_TICK  = 1'b0;
  localparam logic FUNC_START = 1'b1;

  typedef enum logic [3:0] {
    PH_IDLE   = 4'b0001,
    PH_ACCEL  = 4'b0010,
    PH_CRUISE = 4'b0100,
    PH_DECEL  = 4'b1000
  } phase_e;

  typedef struct packed {
    logic               func;
    logic               direction;
    logic [CountW-1:0]  ramp_steps;
    logic [CountW-1:0]  cruise_steps;
  } item_t;

  typedef struct packed {
    phase_e             phase;
    logic [PeriodW-1:0] half_period;
    logic [PeriodW-1:0] tick_count;
    logic [CountW-1:0]  pulse_count;
    logic               second_half;
    logic               direction;
    logic [CountW-1:0]  ramp_steps;
    logic [CountW-1:0]  cruise_steps;
    logic               enabled;
  } state_t;

  typedef struct packed {
    logic step_level;
    logic dir_level;
    logic enable_n;
    logic busy;
    logic start_taken;
  } res_t;

  typedef struct packed {
    logic [PeriodW-1:0] upper;
    logic [PeriodW-1:0] lower;
  } cfg_t;

endpackage
`default_nettype wire

### src/srpg_next.sv
// Next-state and result logic for one request of the pulse generator.
`default_nettype none
module srpg_next (
  input  srpg_pkg::cfg_t   cfg_i,
  input  srpg_pkg::item_t  item_i,
  input  srpg_pkg::state_t cur_i,
  output srpg_pkg::state_t nxt_o,
  output srpg_pkg::res_t   res_o
);

  logic                         is_idle;
  logic                         start_ok;
  logic [srpg_pkg::CountW-1:0]  ramp_v;
  logic [srpg_pkg::CountW-1:0]  cruise_v;
  logic                         ramp_ok;
  srpg_pkg::phase_e             dec_ph;
  logic [srpg_pkg::PeriodW-1:0] dec_g;
  srpg_pkg::phase_e             cru_ph;
  logic [srpg_pkg::PeriodW-1:0] cru_g;
  srpg_pkg::phase_e             seg_ph;
  logic [srpg_pkg::PeriodW-1:0] seg_g;
  logic                         seg_new;
  logic [srpg_pkg::PeriodW-1:0] len;
  logic [srpg_pkg::PeriodW-1:0] tick_inc;
  logic [srpg_pkg::CountW-1:0]  pulse_inc;
  logic [srpg_pkg::CountW-1:0]  need;
  logic [srpg_pkg::PeriodW-1:0] g_dec;
  logic [srpg_pkg::PeriodW:0]   g_inc;

  always_comb begin
    is_idle  = (cur_i.phase == srpg_pkg::PH_IDLE);
    start_ok = (item_i.func == srpg_pkg::FUNC_START) && is_idle;
    ramp_v   = start_ok ? item_i.ramp_steps   : cur_i.ramp_steps;
    cruise_v = start_ok ? item_i.cruise_steps : cur_i.cruise_steps;
    ramp_ok  = (cfg_i.upper > cfg_i.lower) && (ramp_v != '0);

    // Entry into deceleration, or the end of the move if the ramp is empty or upper is not above lower.
    dec_ph = ramp_ok ? srpg_pkg::PH_DECEL : srpg_pkg::PH_IDLE;
    dec_g  = ramp_ok ? cfg_i.lower : '0;
    // Entry into cruise, falling through to deceleration.
    cru_ph = (cruise_v != '0) ? srpg_pkg::PH_CRUISE : dec_ph;
    cru_g  = (cruise_v != '0) ? cfg_i.lower : dec_g;

    len       = (cur_i.half_period == '0) ? {{(srpg_pkg::PeriodW-1){1'b0}}, 1'b1}
                                          : cur_i.half_period;
    tick_inc  = cur_i.tick_count + 1'b1;
    pulse_inc = cur_i.pulse_count + 1'b1;
    need      = (cur_i.phase == srpg_pkg::PH_CRUISE) ? cur_i.cruise_steps
                                                     : cur_i.ramp_steps;
    g_dec     = cur_i.half_period - 1'b1;
    g_inc     = {1'b0, cur_i.half_period} + 1'b1;

    nxt_o   = cur_i;
    res_o   = '0;
    seg_new = 1'b0;
    seg_ph  = srpg_pkg::PH_IDLE;
    seg_g   = '0;

    if (start_ok) begin
      nxt_o.direction    = item_i.direction;
      nxt_o.ramp_steps   = item_i.ramp_steps;
      nxt_o.cruise_steps = item_i.cruise_steps;
      nxt_o.enabled      = 1'b1;
      seg_new            = 1'b1;
      seg_ph             = ramp_ok ? srpg_pkg::PH_ACCEL : cru_ph;
      seg_g              = ramp_ok ? cfg_i.upper : cru_g;
      res_o.start_taken  = 1'b1;
      res_o.step_level   = (seg_ph != srpg_pkg::PH_IDLE);
      res_o.dir_level    = (seg_ph != srpg_pkg::PH_IDLE) && item_i.direction;
    end else if (!is_idle) begin
      res_o.step_level = !cur_i.second_half;
      res_o.dir_level  = cur_i.direction;
      if (item_i.func == srpg_pkg::FUNC_TICK) begin
        if (tick_inc < len) begin
          nxt_o.tick_count = tick_inc;
        end else begin
          nxt_o.tick_count = '0;
          if (!cur_i.second_half) begin
            nxt_o.second_half = 1'b1;
          end else begin
            nxt_o.second_half = 1'b0;
            nxt_o.pulse_count = pulse_inc;
            if (pulse_inc >= need) begin
              seg_new = 1'b1;
              case (cur_i.phase)
                srpg_pkg::PH_ACCEL: begin
                  if ((cur_i.half_period != '0) && (g_dec > cfg_i.lower)) begin
                    seg_ph = srpg_pkg::PH_ACCEL;
                    seg_g  = g_dec;
                  end else begin
                    seg_ph = cru_ph;
                    seg_g  = cru_g;
                  end
                end
                srpg_pkg::PH_CRUISE: begin
                  seg_ph = dec_ph;
                  seg_g  = dec_g;
                end
                default: begin
                  if (g_inc < {1'b0, cfg_i.upper}) begin
                    seg_ph = srpg_pkg::PH_DECEL;
                    seg_g  = g_inc[srpg_pkg::PeriodW-1:0];
                  end
                end
              endcase
            end
          end
        end
      end
    end

    if (seg_new) begin
      nxt_o.phase       = seg_ph;
      nxt_o.half_period = seg_g;
      nxt_o.tick_count  = '0;
      nxt_o.pulse_count = '0;
      nxt_o.second_half = 1'b0;
    end

    res_o.enable_n = !nxt_o.enabled;
    res_o.busy     = (nxt_o.phase != srpg_pkg::PH_IDLE);
  end

endmodule
`default_nettype wire

### src/stepper_ramp_pulse_generator.sv
// A request accepted into the input register moves into the result register once
// that register is empty or its result is being taken. Throughput: one request per
// cycle, held back only when both registers are full and the result is not being taken.
// That rate is set by the state register feeding back through one pass of the
// next-state logic. Reset is asynchronous and active low: the move state goes
// idle with the driver enable cleared, and both half-periods reload.
`default_nettype none
module stepper_ramp_pulse_generator (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  // Request channel.
  input  wire logic                                in_valid_i,
  output logic                                     in_ready_o,
  input  wire logic                                func_i,
  input  wire logic                                direction_i,
  input  wire logic [srpg_pkg::CountW-1:0]         ramp_steps_i,
  input  wire logic [srpg_pkg::CountW-1:0]         cruise_steps_i,
  // Result channel.
  output logic                                     out_valid_o,
  input  wire logic                                out_ready_i,
  output logic                                     step_level_o,
  output logic                                     dir_level_o,
  output logic                                     enable_n_o,
  output logic                                     busy_res_o,
  output logic                                     start_taken_o,
  // Configuration write port.
  input  wire logic                                cfg_we_i,
  input  wire logic [srpg_pkg::CfgIdxW-1:0]        cfg_idx_i,
  input  wire logic [srpg_pkg::PeriodW-1:0]        cfg_wdata_i
);

  // Half-period registers. They are read live by the next-state logic, so a
  // change made between moves applies to the next start.
  srpg_pkg::cfg_t   cfg_q;

  // Input register: one request waiting for its pass through the logic.
  srpg_pkg::item_t  item_q;
  logic             item_vld_q;

  // Move state: phase, counters and the values latched at start.
  srpg_pkg::state_t state_q;
  srpg_pkg::state_t state_d;

  // Result register, which is also the output skid.
  srpg_pkg::res_t   res_q;
  srpg_pkg::res_t   res_d;
  logic             res_vld_q;

  logic             advance;
  srpg_pkg::item_t  item_in;

  // A buffered request moves into the result register whenever that
  // register is empty or is being drained in this very cycle.
  assign advance    = item_vld_q && (!res_vld_q || out_ready_i);
  assign in_ready_o = !item_vld_q || !res_vld_q || out_ready_i;

  always_comb begin
    item_in.func         = func_i;
    item_in.direction    = direction_i;
    item_in.ramp_steps   = ramp_steps_i;
    item_in.cruise_steps = cruise_steps_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.upper <= srpg_pkg::UpperReset;
      cfg_q.lower <= srpg_pkg::LowerReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        srpg_pkg::CFG_UPPER: cfg_q.upper <= cfg_wdata_i;
        srpg_pkg::CFG_LOWER: cfg_q.lower <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      item_vld_q <= in_valid_i;
    end
  end

  // The payload needs no reset; it is only looked at while its valid is set.
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q <= item_in;
    end
  end

  srpg_next u_next (
    .cfg_i  (cfg_q),
    .item_i (item_q),
    .cur_i  (state_q),
    .nxt_o  (state_d),
    .res_o  (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '{phase: srpg_pkg::PH_IDLE, default: '0};
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_vld_q <= 1'b0;
    end else if (advance) begin
      res_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      res_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o   = res_vld_q;
  assign step_level_o  = res_q.step_level;
  assign dir_level_o   = res_q.dir_level;
  assign enable_n_o    = res_q.enable_n;
  assign busy_res_o    = res_q.busy;
  assign start_taken_o = res_q.start_taken;

endmodule
`default_nettype wire

### src/srpg_checker.sv
// Port-level checker for the stepper ramp pulse generator, with its bind.
`default_nettype none
`include "stepper_ramp_pulse_generator_assert.svh"
module srpg_checker (
  input wire logic                         clk_i,
  input wire logic                         rst_ni,
  input wire logic                         out_valid_o,
  input wire logic                         out_ready_i,
  input wire logic                         step_level_o,
  input wire logic                         dir_level_o,
  input wire logic                         enable_n_o,
  input wire logic                         busy_res_o,
  input wire logic                         start_taken_o
);

  logic [4:0] res_bits;

  assign res_bits = {step_level_o, dir_level_o, enable_n_o, busy_res_o, start_taken_o};

  // A stalled result keeps its valid and its levels.
  `SRPG_ASSERT_NEXT(a_res_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(res_bits))

  // An accepted start always leaves the driver enabled.
  `SRPG_ASSERT_NOW(a_start_enables, out_valid_o && start_taken_o, !enable_n_o)

  // Once the driver is enabled it stays enabled until reset.
  `SRPG_ASSERT_NEXT(a_enable_sticks, out_valid_o && !enable_n_o, !enable_n_o)

  // A result that leaves the block idle never shows the step pin high.
  `SRPG_ASSERT_NOW(a_idle_step_low, out_valid_o && !busy_res_o, !step_level_o)

endmodule

bind stepper_ramp_pulse_generator srpg_checker u_srpg_checker (.*);
`default_nettype wire
